### sv/scancode_set1_ascii_decoder_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the scan code decoder
// Same-cycle and next-cycle implication checks under a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef SCANCODE_SET1_ASCII_DECODER_CORE_ASSERT_SVH
`define SCANCODE_SET1_ASCII_DECODER_CORE_ASSERT_SVH

// check cons in the same cycle as ante
`define SCDEC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scdec: same-cycle check failed");

// check cons in the cycle after ante
`define SCDEC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scdec: next-cycle check failed");

`endif

### sv/scdec_pkg.sv
// ----------------------------------------------------------------------------
// scdec_pkg
// Codes, state and result types and character tables of the set-1 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package scdec_pkg;

    localparam logic [7:0] CODE_E0   = 8'hE0;
    localparam logic [7:0] CODE_E1   = 8'hE1;

    localparam logic [6:0] KEY_LSHIFT = 7'h2A;
    localparam logic [6:0] KEY_RSHIFT = 7'h36;
    localparam logic [6:0] KEY_CTRL   = 7'h1D;
    localparam logic [6:0] KEY_ALT    = 7'h38;
    localparam logic [6:0] KEY_CAPS   = 7'h3A;
    localparam logic [6:0] KEY_SCROLL = 7'h46;
    localparam logic [6:0] KEY_SLASH  = 7'd53;
    localparam logic [6:0] KEY_DIV_CODE = 7'd8;
    localparam logic [7:0] CHAR_SLASH = 8'd47;

    localparam logic [6:0] PAD_FIRST = 7'd71;
    localparam logic [6:0] PAD_LAST  = 7'd83;

    localparam logic [6:0] LETTER_A_FIRST = 7'd16;
    localparam logic [6:0] LETTER_A_LAST  = 7'd26;
    localparam logic [6:0] LETTER_B_FIRST = 7'd30;
    localparam logic [6:0] LETTER_B_LAST  = 7'd40;
    localparam logic [6:0] LETTER_C_FIRST = 7'd44;
    localparam logic [6:0] LETTER_C_LAST  = 7'd50;

    localparam logic [1:0] PFX_NONE = 2'd0;
    localparam logic [1:0] PFX_E0   = 2'd1;
    localparam logic [1:0] PFX_E1   = 2'd2;

    typedef struct packed {
        logic [1:0] prefix;
        logic       shift;
        logic       ctrl_left;
        logic       ctrl_right;
        logic       alt_left;
        logic       alt_right;
        logic       caps;
        logic       scroll;
    } t_state;

    typedef struct packed {
        logic       key_valid;
        logic [7:0] ascii_char;
        logic [6:0] key_code;
    } t_result;

    function automatic logic is_letter(input logic [6:0] code);
        return (code >= LETTER_A_FIRST && code <= LETTER_A_LAST) ||
               (code >= LETTER_B_FIRST && code <= LETTER_B_LAST) ||
               (code >= LETTER_C_FIRST && code <= LETTER_C_LAST);
    endfunction

    function automatic logic [7:0] plain_char(input logic [6:0] code);
        logic [7:0] ch;
        case (code)
            7'd2:  ch = 8'd49;
            7'd3:  ch = 8'd50;
            7'd4:  ch = 8'd51;
            7'd5:  ch = 8'd52;
            7'd6:  ch = 8'd53;
            7'd7:  ch = 8'd54;
            7'd8:  ch = 8'd55;
            7'd9:  ch = 8'd56;
            7'd10: ch = 8'd57;
            7'd11: ch = 8'd48;
            7'd12: ch = 8'd225;
            7'd13: ch = 8'd39;
            7'd14: ch = 8'd8;
            7'd16: ch = 8'd113;
            7'd17: ch = 8'd119;
            7'd18: ch = 8'd101;
            7'd19: ch = 8'd114;
            7'd20: ch = 8'd116;
            7'd21: ch = 8'd122;
            7'd22: ch = 8'd117;
            7'd23: ch = 8'd105;
            7'd24: ch = 8'd111;
            7'd25: ch = 8'd112;
            7'd26: ch = 8'd129;
            7'd27: ch = 8'd43;
            7'd28: ch = 8'd10;
            7'd30: ch = 8'd97;
            7'd31: ch = 8'd115;
            7'd32: ch = 8'd100;
            7'd33: ch = 8'd102;
            7'd34: ch = 8'd103;
            7'd35: ch = 8'd104;
            7'd36: ch = 8'd106;
            7'd37: ch = 8'd107;
            7'd38: ch = 8'd108;
            7'd39: ch = 8'd148;
            7'd40: ch = 8'd132;
            7'd41: ch = 8'd94;
            7'd43: ch = 8'd35;
            7'd44: ch = 8'd121;
            7'd45: ch = 8'd120;
            7'd46: ch = 8'd99;
            7'd47: ch = 8'd118;
            7'd48: ch = 8'd98;
            7'd49: ch = 8'd110;
            7'd50: ch = 8'd109;
            7'd51: ch = 8'd44;
            7'd52: ch = 8'd46;
            7'd53: ch = 8'd45;
            7'd55: ch = 8'd42;
            7'd57: ch = 8'd32;
            7'd74: ch = 8'd45;
            7'd78: ch = 8'd43;
            7'd86: ch = 8'd60;
            default: ch = 8'd0;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] upper_char(input logic [6:0] code);
        logic [7:0] ch;
        case (code)
            7'd2:  ch = 8'd33;
            7'd3:  ch = 8'd34;
            7'd4:  ch = 8'd21;
            7'd5:  ch = 8'd36;
            7'd6:  ch = 8'd37;
            7'd7:  ch = 8'd38;
            7'd8:  ch = 8'd47;
            7'd9:  ch = 8'd40;
            7'd10: ch = 8'd41;
            7'd11: ch = 8'd61;
            7'd12: ch = 8'd63;
            7'd13: ch = 8'd96;
            7'd16: ch = 8'd81;
            7'd17: ch = 8'd87;
            7'd18: ch = 8'd69;
            7'd19: ch = 8'd82;
            7'd20: ch = 8'd84;
            7'd21: ch = 8'd90;
            7'd22: ch = 8'd85;
            7'd23: ch = 8'd73;
            7'd24: ch = 8'd79;
            7'd25: ch = 8'd80;
            7'd26: ch = 8'd154;
            7'd27: ch = 8'd42;
            7'd30: ch = 8'd65;
            7'd31: ch = 8'd83;
            7'd32: ch = 8'd68;
            7'd33: ch = 8'd70;
            7'd34: ch = 8'd71;
            7'd35: ch = 8'd72;
            7'd36: ch = 8'd74;
            7'd37: ch = 8'd75;
            7'd38: ch = 8'd76;
            7'd39: ch = 8'd153;
            7'd40: ch = 8'd142;
            7'd41: ch = 8'd248;
            7'd43: ch = 8'd39;
            7'd44: ch = 8'd89;
            7'd45: ch = 8'd88;
            7'd46: ch = 8'd67;
            7'd47: ch = 8'd86;
            7'd48: ch = 8'd66;
            7'd49: ch = 8'd78;
            7'd50: ch = 8'd77;
            7'd51: ch = 8'd59;
            7'd52: ch = 8'd58;
            7'd53: ch = 8'd95;
            7'd57: ch = 8'd32;
            7'd86: ch = 8'd62;
            default: ch = 8'd0;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] altgr_char(input logic [6:0] code);
        logic [7:0] ch;
        case (code)
            7'd3:  ch = 8'd253;
            7'd8:  ch = 8'd123;
            7'd9:  ch = 8'd91;
            7'd10: ch = 8'd93;
            7'd11: ch = 8'd125;
            7'd12: ch = 8'd92;
            7'd16: ch = 8'd64;
            7'd27: ch = 8'd126;
            7'd50: ch = 8'd230;
            7'd86: ch = 8'd124;
            default: ch = 8'd0;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] pad_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:  ch = 8'd55;
            4'd1:  ch = 8'd56;
            4'd2:  ch = 8'd57;
            4'd3:  ch = 8'd45;
            4'd4:  ch = 8'd52;
            4'd5:  ch = 8'd53;
            4'd6:  ch = 8'd54;
            4'd7:  ch = 8'd43;
            4'd8:  ch = 8'd49;
            4'd9:  ch = 8'd50;
            4'd10: ch = 8'd51;
            4'd11: ch = 8'd48;
            4'd12: ch = 8'd44;
            default: ch = 8'd0;
        endcase
        return ch;
    endfunction

    function automatic logic [6:0] pad_code(input logic [3:0] idx);
        logic [6:0] kc;
        case (idx)
            4'd0:  kc = 7'd8;
            4'd1:  kc = 7'd9;
            4'd2:  kc = 7'd10;
            4'd3:  kc = 7'd53;
            4'd4:  kc = 7'd5;
            4'd5:  kc = 7'd6;
            4'd6:  kc = 7'd7;
            4'd7:  kc = 7'd27;
            4'd8:  kc = 7'd2;
            4'd9:  kc = 7'd3;
            4'd10: kc = 7'd4;
            4'd11: kc = 7'd11;
            4'd12: kc = 7'd51;
            default: kc = 7'd0;
        endcase
        return kc;
    endfunction

endpackage

`default_nettype wire

### sv/scancode_set1_ascii_decoder_core.sv
// ----------------------------------------------------------------------------
// scancode_set1_ascii_decoder_core
// Set-1 keyboard scan code to character decoder, German layout.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one scan code byte per word.
// Output channel: o_out_valid / i_out_stall carry one result word per input
// word: key_valid, ascii_char, key_code and the modifier and lock flags as
// they stand after that byte.
// Configuration: i_cfg_wr_en writes i_cfg_wr_data into num_lock; write it
// only while no word is in flight.
// Path: a word accepted lands in the input register, and its result is loaded
// into the output register when the output is not stalled.
// Throughput: one word per cycle while the output is not stalled, set by the
// single decode stage that sits between the input register and the output
// register and updates the modifier state in the same cycle.
// Reset clears num_lock, the prefix, all modifier and lock flags and the valid
// flags of both pipeline stages. A stall on the output holds the result word; the input
// register fills and then stalls the input channel in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "scancode_set1_ascii_decoder_core_assert.svh"

module scancode_set1_ascii_decoder_core (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_wr_en,
    input  wire logic       i_cfg_wr_data,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_scan_code,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic            o_key_valid,
    output logic [7:0]      o_ascii_char,
    output logic [6:0]      o_key_code,
    output logic            o_shift_held,
    output logic            o_ctrl_left_held,
    output logic            o_ctrl_right_held,
    output logic            o_alt_left_held,
    output logic            o_alt_right_held,
    output logic            o_caps_on,
    output logic            o_scroll_on
);

    logic                r_num_lock;
    logic                r_in_valid;
    logic [7:0]          r_scan_code;
    logic                r_out_valid;
    scdec_pkg::t_state   r_state;
    scdec_pkg::t_state   n_state;
    scdec_pkg::t_state   r_out_state;
    scdec_pkg::t_result  r_out_res;
    scdec_pkg::t_result  n_res;
    logic                advance;
    logic                in_load;

    assign advance    = ~r_out_valid | ~i_out_stall;
    assign in_load    = ~r_in_valid | advance;
    assign o_in_stall = ~in_load;

    scdec_decode u_decode (
        .i_scan_code (r_scan_code),
        .i_num_lock  (r_num_lock),
        .i_state     (r_state),
        .o_state     (n_state),
        .o_result    (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_lock <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_num_lock <= i_cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_load) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_load && i_in_valid) begin
            r_scan_code <= i_scan_code;
        end
    end

    // decode state and output register advance together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (r_in_valid) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_valid) begin
            r_out_res   <= n_res;
            r_out_state <= n_state;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_key_valid       = r_out_res.key_valid;
    assign o_ascii_char      = r_out_res.ascii_char;
    assign o_key_code        = r_out_res.key_code;
    assign o_shift_held      = r_out_state.shift;
    assign o_ctrl_left_held  = r_out_state.ctrl_left;
    assign o_ctrl_right_held = r_out_state.ctrl_right;
    assign o_alt_left_held   = r_out_state.alt_left;
    assign o_alt_right_held  = r_out_state.alt_right;
    assign o_caps_on         = r_out_state.caps;
    assign o_scroll_on       = r_out_state.scroll;

    `SCDEC_ASSERT_IMPL(a_empty_not_stalled, i_clk, i_rst_n, !r_in_valid, !o_in_stall)
    `SCDEC_ASSERT_NEXT(a_advance_lands, i_clk, i_rst_n, r_in_valid && advance, r_out_valid)
    `SCDEC_ASSERT_IMPL(a_flags_track_state, i_clk, i_rst_n, r_out_valid, r_out_state == r_state)
    `SCDEC_ASSERT_IMPL(a_key_clears_prefix, i_clk, i_rst_n, r_out_valid && o_key_valid, r_state.prefix == scdec_pkg::PFX_NONE)

endmodule

`default_nettype wire

### sv/scdec_decode.sv
// ----------------------------------------------------------------------------
// scdec_decode
// Next modifier/prefix state and decoded character for one scan code byte.
// ----------------------------------------------------------------------------
`default_nettype none

module scdec_decode (
    input  wire logic [7:0]        i_scan_code,
    input  wire logic              i_num_lock,
    input  wire scdec_pkg::t_state i_state,
    output scdec_pkg::t_state      o_state,
    output scdec_pkg::t_result     o_result
);

    logic [6:0] code7;
    logic [3:0] pad_idx;
    logic       is_pad;

    assign code7   = i_scan_code[6:0];
    assign pad_idx = 4'(code7 - scdec_pkg::PAD_FIRST);
    assign is_pad  = (code7 >= scdec_pkg::PAD_FIRST) && (code7 <= scdec_pkg::PAD_LAST);

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        if (i_scan_code == scdec_pkg::CODE_E0) begin
            o_state.prefix = scdec_pkg::PFX_E0;
        end else if (i_scan_code == scdec_pkg::CODE_E1) begin
            o_state.prefix = scdec_pkg::PFX_E1;
        end else if (i_scan_code[7]) begin
            if (code7 == scdec_pkg::KEY_LSHIFT || code7 == scdec_pkg::KEY_RSHIFT) begin
                o_state.shift = 1'b0;
            end else if (code7 == scdec_pkg::KEY_CTRL) begin
                if (i_state.prefix == scdec_pkg::PFX_E0) begin
                    o_state.ctrl_right = 1'b0;
                end else begin
                    o_state.ctrl_left = 1'b0;
                end
            end else if (code7 == scdec_pkg::KEY_ALT) begin
                if (i_state.prefix == scdec_pkg::PFX_E0) begin
                    o_state.alt_right = 1'b0;
                end else begin
                    o_state.alt_left = 1'b0;
                end
            end
            o_state.prefix = scdec_pkg::PFX_NONE;
        end else if (code7 == scdec_pkg::KEY_LSHIFT || code7 == scdec_pkg::KEY_RSHIFT) begin
            o_state.shift = 1'b1;
        end else if (code7 == scdec_pkg::KEY_CTRL) begin
            if (i_state.prefix == scdec_pkg::PFX_E0) begin
                o_state.ctrl_right = 1'b1;
            end else begin
                o_state.ctrl_left = 1'b1;
            end
        end else if (code7 == scdec_pkg::KEY_ALT) begin
            if (i_state.prefix == scdec_pkg::PFX_E0) begin
                o_state.alt_right = 1'b1;
            end else begin
                o_state.alt_left = 1'b1;
            end
        end else if (code7 == scdec_pkg::KEY_CAPS) begin
            o_state.caps = ~i_state.caps;
        end else if (code7 == scdec_pkg::KEY_SCROLL) begin
            o_state.scroll = ~i_state.scroll;
        end else begin
            o_result.key_valid = 1'b1;
            o_result.key_code  = code7;
            if (code7 == scdec_pkg::KEY_SLASH && i_state.prefix == scdec_pkg::PFX_E0) begin
                o_result.ascii_char = scdec_pkg::CHAR_SLASH;
                o_result.key_code   = scdec_pkg::KEY_DIV_CODE;
            end else if (i_num_lock && i_state.prefix == scdec_pkg::PFX_NONE && is_pad) begin
                o_result.ascii_char = scdec_pkg::pad_char(pad_idx);
                o_result.key_code   = scdec_pkg::pad_code(pad_idx);
            end else if (i_state.alt_right) begin
                o_result.ascii_char = scdec_pkg::altgr_char(code7);
            end else if (i_state.shift) begin
                o_result.ascii_char = scdec_pkg::upper_char(code7);
            end else if (i_state.caps && scdec_pkg::is_letter(code7)) begin
                o_result.ascii_char = scdec_pkg::upper_char(code7);
            end else begin
                o_result.ascii_char = scdec_pkg::plain_char(code7);
            end
            o_state.prefix = scdec_pkg::PFX_NONE;
        end
    end

endmodule

`default_nettype wire
